// ----- rtl/vn_pkg.sv -----
// vn_pkg: shared types and constants for the vector_normalize_3d pipeline.
// No dependencies.
`default_nettype none
package vn_pkg;

  localparam int unsigned CompW     = 32;
  localparam int unsigned SumW      = 64;
  localparam int unsigned RootW     = 32;
  localparam int unsigned QuotW     = 31;
  localparam int unsigned OutFrac   = 30;
  localparam int unsigned SqrtSteps = RootW;
  localparam int unsigned DivSteps  = QuotW;

  // raw item fields that ride alongside the arithmetic
  typedef struct packed {
    logic               func;
    logic [CompW-1:0]   x;
    logic [CompW-1:0]   y;
    logic [CompW-1:0]   z;
    logic [CompW-1:0]   w;
  } side_t;

endpackage
`default_nettype wire

// ----- rtl/vn_square.sv -----
// vn_square: magnitudes, squares and sum of squares, two register stages.
// Depends on vn_pkg.
`default_nettype none
module vn_square (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     en,
  input  wire logic                     vld_in,
  input  wire vn_pkg::side_t            side_in,
  output logic                          vld_out,
  output vn_pkg::side_t                 side_out,
  output logic [vn_pkg::SumW-1:0]       sum_out
);

  logic [vn_pkg::CompW-1:0] ax, ay, az;
  logic [vn_pkg::SumW-1:0]  sqx_r, sqy_r, sqz_r, sum_r;
  logic                     v1_r, v2_r;
  vn_pkg::side_t            s1_r, s2_r;

  // two's complement magnitude; -2^31 maps to 2^31 unsigned
  assign ax = side_in.x[31] ? (~side_in.x + 32'd1) : side_in.x;
  assign ay = side_in.y[31] ? (~side_in.y + 32'd1) : side_in.y;
  assign az = side_in.z[31] ? (~side_in.z + 32'd1) : side_in.z;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_in;
      v2_r <= v1_r;
    end
  end

  // stage 1 squares, stage 2 sum
  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r <= {32'd0, ax} * {32'd0, ax};
      sqy_r <= {32'd0, ay} * {32'd0, ay};
      sqz_r <= {32'd0, az} * {32'd0, az};
      s1_r  <= side_in;
      sum_r <= sqx_r + sqy_r + sqz_r;
      s2_r  <= s1_r;
    end
  end

  assign vld_out  = v2_r;
  assign side_out = s2_r;
  assign sum_out  = sum_r;

endmodule
`default_nettype wire

// ----- rtl/vn_sqrt.sv -----
// vn_sqrt: pipelined integer square root, one root bit per register stage.
// Depends on vn_pkg.
`default_nettype none
module vn_sqrt (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     en,
  input  wire logic                     vld_in,
  input  wire vn_pkg::side_t            side_in,
  input  wire logic [vn_pkg::SumW-1:0]  sum_in,
  output logic                          vld_out,
  output vn_pkg::side_t                 side_out,
  output logic [vn_pkg::RootW-1:0]      root_out
);

  localparam int unsigned N = vn_pkg::SqrtSteps;

  logic [33:0]               rem_r  [N];
  logic [vn_pkg::RootW-1:0]  root_r [N];
  logic [vn_pkg::SumW-1:0]   s_r    [N];
  vn_pkg::side_t             side_r [N];
  logic [N-1:0]              vld_r;

  for (genvar i = 0; i < N; i++) begin : g_step
    logic [33:0]              rem_p;
    logic [vn_pkg::RootW-1:0] root_p;
    logic [vn_pkg::SumW-1:0]  s_p;
    logic [35:0]              cur, trial;
    logic                     ge;

    if (i == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign s_p    = sum_in;
    end else begin : g_next
      assign rem_p  = rem_r[i-1];
      assign root_p = root_r[i-1];
      assign s_p    = s_r[i-1];
    end

    // bring down two radicand bits, try root*4+1
    assign cur   = {rem_p, s_p[63:62]};
    assign trial = {2'b00, root_p, 2'b01};
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= ge ? 34'(cur - trial) : cur[33:0];
        root_r[i] <= {root_p[vn_pkg::RootW-2:0], ge};
        s_r[i]    <= {s_p[61:0], 2'b00};
        side_r[i] <= (i == 0) ? side_in : side_r[(i == 0) ? 0 : i-1];
      end
    end
  end

  // valid bits follow the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N-2:0], vld_in};
    end
  end

  assign vld_out  = vld_r[N-1];
  assign side_out = side_r[N-1];
  assign root_out = root_r[N-1];

endmodule
`default_nettype wire

// ----- rtl/vn_div.sv -----
// vn_div: pipelined restoring divider forming round(m * 2^30 / len),
// one quotient bit per register stage. Depends on vn_pkg.
`default_nettype none
module vn_div (
  input  wire logic                      clk,
  input  wire logic                      en,
  input  wire logic [vn_pkg::CompW-1:0]  mag_in,
  input  wire logic [vn_pkg::RootW-1:0]  len_in,
  output logic [vn_pkg::QuotW-1:0]       quot_out
);

  localparam int unsigned N = vn_pkg::DivSteps;

  logic [61:0]               num;
  logic [31:0]               rem_r  [N];
  logic [30:0]               nr_r   [N];
  logic [vn_pkg::QuotW-1:0]  q_r    [N];
  logic [vn_pkg::RootW-1:0]  len_r  [N];

  // numerator with half the divisor added for rounding
  assign num = {mag_in[31:0], 30'd0} + {31'd0, len_in[31:1]};

  for (genvar i = 0; i < N; i++) begin : g_step
    logic [31:0]              rem_p;
    logic [30:0]              nr_p;
    logic [vn_pkg::QuotW-1:0] q_p;
    logic [vn_pkg::RootW-1:0] len_p;
    logic [32:0]              cur;
    logic                     ge;

    if (i == 0) begin : g_first
      assign rem_p = {1'b0, num[61:31]};
      assign nr_p  = num[30:0];
      assign q_p   = '0;
      assign len_p = len_in;
    end else begin : g_next
      assign rem_p = rem_r[i-1];
      assign nr_p  = nr_r[i-1];
      assign q_p   = q_r[i-1];
      assign len_p = len_r[i-1];
    end

    assign cur = {rem_p, nr_p[30]};
    assign ge  = (cur >= {1'b0, len_p});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? 32'(cur - {1'b0, len_p}) : cur[31:0];
        nr_r[i]  <= {nr_p[29:0], 1'b0};
        q_r[i]   <= {q_p[vn_pkg::QuotW-2:0], ge};
        len_r[i] <= len_p;
      end
    end
  end

  assign quot_out = q_r[N-1];

endmodule
`default_nettype wire

// ----- rtl/vector_normalize_3d.sv -----
// vector_normalize_3d: top level; squares, square root, three dividers, output.
// Depends on vn_pkg, vn_square, vn_sqrt, vn_div.
//
// Normalizes one signed 3-D vector per item to Q2.30 components and returns
// its length. The pipeline takes one item every clock cycle while it is not
// stalled. An item passes through 66 register stages: 2 square/sum stages,
// 32 square-root stages, 31 divider stages and one result register. The
// whole pipeline advances while the output register is empty or being taken,
// so in_tready drops only while a result waits at the output. A zero-length
// vector passes x, y and z through (w only when func is set) and raises the
// zero_length flag in tuser.
`default_nettype none
module vector_normalize_3d (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [127:0]  in_tdata,   // x_in, y_in, z_in, w_in
  input  wire logic          in_tuser,   // func
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [167:0]       out_tdata,  // x_out, y_out, z_out, w_out, length_out, pad
  output logic               out_tuser   // zero_length
);

  localparam int unsigned ND = vn_pkg::DivSteps;

  logic                        en;
  vn_pkg::side_t               side_in, sq_side, rt_side;
  logic                        sq_vld, rt_vld;
  logic [vn_pkg::SumW-1:0]     sq_sum;
  logic [vn_pkg::RootW-1:0]    root;
  logic [vn_pkg::CompW-1:0]    mx, my, mz;
  logic [vn_pkg::QuotW-1:0]    qx, qy, qz;
  vn_pkg::side_t               dside_r [ND];
  logic [vn_pkg::RootW-1:0]    dlen_r  [ND];
  logic [ND-1:0]               dvld_r;
  vn_pkg::side_t               fs;
  logic [vn_pkg::RootW-1:0]    flen;
  logic                        fzero;
  logic                        out_valid_r;
  logic [167:0]                out_data_r;
  logic                        out_user_r;
  logic [31:0]                 rx, ry, rz, rw;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  assign side_in.func = in_tuser;
  assign side_in.x    = in_tdata[31:0];
  assign side_in.y    = in_tdata[63:32];
  assign side_in.z    = in_tdata[95:64];
  assign side_in.w    = in_tdata[127:96];

  vn_square u_square (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_in(in_tvalid && in_tready), .side_in(side_in),
    .vld_out(sq_vld), .side_out(sq_side), .sum_out(sq_sum)
  );

  vn_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_in(sq_vld), .side_in(sq_side), .sum_in(sq_sum),
    .vld_out(rt_vld), .side_out(rt_side), .root_out(root)
  );

  // component magnitudes for the dividers
  assign mx = rt_side.x[31] ? (~rt_side.x + 32'd1) : rt_side.x;
  assign my = rt_side.y[31] ? (~rt_side.y + 32'd1) : rt_side.y;
  assign mz = rt_side.z[31] ? (~rt_side.z + 32'd1) : rt_side.z;

  vn_div u_div_x (.clk(clk), .en(en), .mag_in(mx), .len_in(root), .quot_out(qx));
  vn_div u_div_y (.clk(clk), .en(en), .mag_in(my), .len_in(root), .quot_out(qy));
  vn_div u_div_z (.clk(clk), .en(en), .mag_in(mz), .len_in(root), .quot_out(qz));

  // raw fields and length delayed to match the dividers
  always_ff @(posedge clk) begin
    if (en) begin
      dside_r[0] <= rt_side;
      dlen_r[0]  <= root;
      for (int i = 1; i < ND; i++) begin
        dside_r[i] <= dside_r[i-1];
        dlen_r[i]  <= dlen_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvld_r <= '0;
    end else if (en) begin
      dvld_r <= {dvld_r[ND-2:0], rt_vld};
    end
  end

  // sign restore and zero-length pass-through
  assign fs    = dside_r[ND-1];
  assign flen  = dlen_r[ND-1];
  assign fzero = (flen == '0);
  assign rx = fzero ? fs.x : (fs.x[31] ? (~{1'b0, qx} + 32'd1) : {1'b0, qx});
  assign ry = fzero ? fs.y : (fs.y[31] ? (~{1'b0, qy} + 32'd1) : {1'b0, qy});
  assign rz = fzero ? fs.z : (fs.z[31] ? (~{1'b0, qz} + 32'd1) : {1'b0, qz});
  assign rw = (fzero && fs.func) ? fs.w : 32'd0;

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dvld_r[ND-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {7'd0, 1'b0, flen, rw, rz, ry, rx};
      out_user_r <= fzero;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// tb_top: self-checking testbench for vector_normalize_3d.
// Depends on rtl/vn_pkg.sv and rtl/vector_normalize_3d.sv; drives random stalls on both sides
// and compares every result against a predictor of the normalization.
`default_nettype none
module tb_top;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [31:0] w;
    logic [32:0] len;
    logic        zero;
  } unit_vec_t;

  localparam int unsigned PipeDepth = 66;
  localparam int unsigned StallLimit = 2000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [167:0] out_tdata;
  logic         out_tuser;

  unit_vec_t    expected_q[$];
  int           errors = 0;
  int           idle_cycles = 0;

  vector_normalize_3d dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always #4 clk = ~clk;

  // floor square root of a 64-bit sum, bit by bit
  function automatic logic [63:0] floor_sqrt(input logic [63:0] s);
    logic [63:0] root;
    logic [63:0] bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= root + bitv) begin
        s = s - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // component / length in Q2.30, rounded half away from zero
  function automatic logic [31:0] scale_to_unit(input logic [31:0] c, input logic [63:0] len);
    logic [63:0] mag;
    logic [63:0] q;
    mag = c[31] ? (64'd0 - {{32{1'b1}}, c}) : {32'd0, c};
    q = ((mag << vn_pkg::OutFrac) + (len >> 1)) / len;
    if (c[31]) q = 64'd0 - q;
    return q[31:0];
  endfunction

  function automatic unit_vec_t normalize(input logic homog, input logic [31:0] x,
                                          input logic [31:0] y, input logic [31:0] z,
                                          input logic [31:0] w);
    unit_vec_t r;
    logic [63:0] ax, ay, az, len;
    ax = x[31] ? (64'd0 - {{32{1'b1}}, x}) : {32'd0, x};
    ay = y[31] ? (64'd0 - {{32{1'b1}}, y}) : {32'd0, y};
    az = z[31] ? (64'd0 - {{32{1'b1}}, z}) : {32'd0, z};
    len = floor_sqrt(ax * ax + ay * ay + az * az);
    if (len == 0) begin
      r = '{x: x, y: y, z: z, w: homog ? w : 32'd0, len: 33'd0, zero: 1'b1};
    end else begin
      r = '{x: scale_to_unit(x, len), y: scale_to_unit(y, len), z: scale_to_unit(z, len),
            w: 32'd0, len: len[32:0], zero: 1'b0};
    end
    return r;
  endfunction

  // send one item after a random gap
  task automatic send_vector(input logic homog, input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] z, input logic [31:0] w);
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {w, z, y, x};
    in_tuser  <= homog;
    expected_q.push_back(normalize(homog, x, y, z, w));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic finish_stream();
    in_tvalid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 4) - 2;
      3: return {{16{1'b0}}, 16'($urandom)} ^ {32{$urandom_range(0, 1) == 1}};
      default: return $urandom;
    endcase
  endfunction

  // extremes, zero vectors in both modes, most negative components
  task automatic test_directed();
    send_vector(1'b0, 32'd0, 32'd0, 32'd0, 32'h1234_5678);
    send_vector(1'b1, 32'd0, 32'd0, 32'd0, 32'hDEAD_BEEF);
    send_vector(1'b1, 32'd0, 32'd0, 32'd0, 32'h8000_0000);
    send_vector(1'b0, 32'h0001_0000, 32'd0, 32'd0, 32'hFFFF_FFFF);
    send_vector(1'b1, 32'd0, 32'hFFFF_0000, 32'd0, 32'h7FFF_FFFF);
    send_vector(1'b0, 32'd0, 32'd0, 32'd1, 32'd0);
    send_vector(1'b1, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'd5);
    send_vector(1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd0);
    send_vector(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    send_vector(1'b0, 32'h8000_0000, 32'd0, 32'd0, 32'd0);
    send_vector(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'h5555_5555);
    send_vector(1'b0, 32'd1, 32'd1, 32'd1, 32'hAAAA_AAAA);
    send_vector(1'b0, 32'd3, 32'hFFFF_FFFC, 32'd0, 32'd0);
    send_vector(1'b1, 32'h0003_0000, 32'h0004_0000, 32'h000C_0000, 32'd0);
    finish_stream();
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_vector(1'($urandom_range(0, 1)), 32'd0, 32'd0, 32'd0, $urandom);
      else
        send_vector(1'($urandom_range(0, 1)), rand_comp(), rand_comp(), rand_comp(),
                    $urandom);
    end
    finish_stream();
  endtask

  // back to back with no gaps on the input side; the receiver still stalls
  task automatic test_full_rate(input int count);
    for (int i = 0; i < count; i++) begin
      in_tvalid <= 1'b1;
      in_tdata  <= {$urandom, rand_comp(), rand_comp(), rand_comp()};
      in_tuser  <= 1'($urandom_range(0, 1));
      @(posedge clk);
      while (!in_tready) @(posedge clk);
      expected_q.push_back(normalize(in_tuser, in_tdata[31:0], in_tdata[63:32],
                                     in_tdata[95:64], in_tdata[127:96]));
      @(negedge clk);
    end
    finish_stream();
  endtask

  // receiver stalls; bursts with no stall from time to time once idle_cycles is set
  initial begin
    int wait_n;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (idle_cycles > 0 && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b1;
        repeat ($urandom_range(10, 80)) @(negedge clk);
      end
      wait_n = $urandom_range(0, 6);
      if (wait_n > 0) begin
        out_tready <= 1'b0;
        repeat (wait_n) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // result check
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      unit_vec_t got, exp_v;
      got = '{x: out_tdata[31:0], y: out_tdata[63:32], z: out_tdata[95:64],
              w: out_tdata[127:96], len: out_tdata[160:128], zero: out_tuser};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_tdata);
        errors++;
      end else begin
        exp_v = expected_q.pop_front();
        if (got.x !== exp_v.x) begin
          $display("%0t: x_out expected %h actual %h", $time, exp_v.x, got.x); errors++;
        end
        if (got.y !== exp_v.y) begin
          $display("%0t: y_out expected %h actual %h", $time, exp_v.y, got.y); errors++;
        end
        if (got.z !== exp_v.z) begin
          $display("%0t: z_out expected %h actual %h", $time, exp_v.z, got.z); errors++;
        end
        if (got.w !== exp_v.w) begin
          $display("%0t: w_out expected %h actual %h", $time, exp_v.w, got.w); errors++;
        end
        if (got.len !== exp_v.len) begin
          $display("%0t: length_out expected %h actual %h", $time, exp_v.len, got.len);
          errors++;
        end
        if (got.zero !== exp_v.zero) begin
          $display("%0t: zero_length expected %b actual %b", $time, exp_v.zero, got.zero);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no handshake
  int stuck = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck >= StallLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random(600);
    idle_cycles = 1;
    test_full_rate(320);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (PipeDepth + 10) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
rtl/vn_pkg.sv
rtl/vn_square.sv
rtl/vn_sqrt.sv
rtl/vn_div.sv
rtl/vector_normalize_3d.sv
sim/tb_top.sv
